// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, action codes, sequencer
// states, request struct and the magnitude helper. No dependencies.
`default_nettype none
package rau_pkg;
    localparam int OPW = 16;
    localparam int PW  = 2 * OPW;
    localparam int NW  = PW + 1;
    localparam int MW  = NW;
    localparam int KW  = $clog2(MW + 1);
    localparam int AW  = 4;
    localparam int RNW = 33;
    localparam int RDW = 32;

    localparam logic [AW-1:0] ACT_ADD = 4'd0;
    localparam logic [AW-1:0] ACT_SUB = 4'd1;
    localparam logic [AW-1:0] ACT_MUL = 4'd2;
    localparam logic [AW-1:0] ACT_DIV = 4'd3;
    localparam logic [AW-1:0] ACT_EQ  = 4'd4;
    localparam logic [AW-1:0] ACT_NE  = 4'd5;
    localparam logic [AW-1:0] ACT_GT  = 4'd6;
    localparam logic [AW-1:0] ACT_LT  = 4'd7;
    localparam logic [AW-1:0] ACT_GE  = 4'd8;
    localparam logic [AW-1:0] ACT_LE  = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_L, ST_MUL_R, ST_MUL_D, ST_FORM,
        ST_GCD, ST_DIV_NUM, ST_DIV_DEN, ST_OUT
    } t_state;

    typedef struct packed {
        logic          start;
        logic [MW-1:0] a;
        logic [MW-1:0] b;
    } t_unit_req;

    function automatic logic [MW-1:0] mag(input logic signed [NW-1:0] x);
        logic [NW-1:0] t;
        t = x[NW-1] ? (~x + 1'b1) : x;
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/rau_if.sv =====
// Valid/ready channel interfaces of the rational arithmetic unit.
// Depends on rau_pkg.
`default_nettype none
interface rau_in_if import rau_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [AW-1:0]         action;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
    modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [RNW-1:0] res_num;
    logic signed [RDW-1:0] res_den;
    logic                  compare_true;
    logic                  undefined;
    modport source (output valid, res_num, res_den, compare_true, undefined, input ready);
    modport sink   (input valid, res_num, res_den, compare_true, undefined, output ready);
endinterface
`default_nettype wire

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit top: sequencer, shared multiplier, gcd and divider.
// Depends on rau_pkg, rau_if, rau_gcd, rau_div.
//
// channel  dir  handshake     payload
// i_in     in   valid/ready   action, a_num, a_den, b_num, b_den
// o_out    out  valid/ready   res_num, res_den, compare_true, undefined
//
// One item at a time. Comparisons and trivial results take three multiplies on
// one 16x16 multiplier and a form step, then the output transfer.
// Reduced results add the binary gcd (one shift or subtract per step) and two
// divisions on one shared divider.
// i_in.ready is high only when idle; a stalled result holds in o_out.
// Synchronous active-low reset returns the sequencer to idle.
`default_nettype none
module rational_arithmetic_unit_core import rau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    t_state r_state, n_state;

    logic [AW-1:0]         r_act;
    logic signed [OPW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0]  r_pl, r_pr, r_pd;
    logic signed [NW-1:0]  r_num;
    logic signed [PW-1:0]  r_den;
    logic                  r_cmp, r_undef;

    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  prod;
    logic signed [NW-1:0]  n_num;
    logic                  n_cmp, arith, is_cmp, pos, to_gcd;
    logic signed [NW-1:0]  pl_x, pr_x, den_x;

    t_unit_req             gcd_req, div_req;
    logic                  gcd_done, div_done;
    logic [MW-1:0]         gcd_val, quot;

    assign arith  = r_act <= ACT_DIV;
    assign is_cmp = (r_act >= ACT_EQ) && (r_act <= ACT_LE);
    assign pl_x   = NW'(r_pl);
    assign pr_x   = NW'(r_pr);
    assign den_x  = NW'(r_den);
    assign pos    = r_pd > 0;

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (r_state)
            ST_MUL_L: begin
                mul_a = r_an;
                mul_b = (r_act == ACT_MUL) ? r_bn : r_bd;
            end
            ST_MUL_R: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            ST_MUL_D: begin
                mul_a = r_ad;
                mul_b = (r_act == ACT_DIV) ? r_bn : r_bd;
            end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    always_comb begin
        case (r_act)
            ACT_ADD: n_num = pl_x + pr_x;
            ACT_SUB: n_num = pl_x - pr_x;
            default: n_num = pl_x;
        endcase
        case (r_act)
            ACT_EQ:  n_cmp = r_pl == r_pr;
            ACT_NE:  n_cmp = r_pl != r_pr;
            ACT_GT:  n_cmp = pos ? (r_pl > r_pr)  : (r_pl <= r_pr);
            ACT_LT:  n_cmp = pos ? (r_pl < r_pr)  : (r_pl >= r_pr);
            ACT_GE:  n_cmp = pos ? (r_pl >= r_pr) : (r_pl < r_pr);
            ACT_LE:  n_cmp = pos ? (r_pl <= r_pr) : (r_pl > r_pr);
            default: n_cmp = 1'b0;
        endcase
    end

    assign to_gcd = arith && (n_num != 0) && (r_pd != 0);

    always_comb begin
        gcd_req.start = (r_state == ST_FORM) && to_gcd;
        gcd_req.a     = mag(n_num);
        gcd_req.b     = mag(NW'(r_pd));
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.a     = mag(r_num);
        div_req.b     = gcd_val;
        if (r_state == ST_GCD && gcd_done) begin
            div_req.start = 1'b1;
        end else if (r_state == ST_DIV_NUM && div_done) begin
            div_req.start = 1'b1;
            div_req.a     = mag(den_x);
        end
    end

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (gcd_req),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in.valid) n_state = ST_MUL_L;
            ST_MUL_L:   n_state = ST_MUL_R;
            ST_MUL_R:   n_state = ST_MUL_D;
            ST_MUL_D:   n_state = ST_FORM;
            ST_FORM:    n_state = to_gcd ? ST_GCD : ST_OUT;
            ST_GCD:     if (gcd_done) n_state = ST_DIV_NUM;
            ST_DIV_NUM: if (div_done) n_state = ST_DIV_DEN;
            ST_DIV_DEN: if (div_done) n_state = ST_OUT;
            ST_OUT:     if (o_out.ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_act <= i_in.action;
                r_an  <= i_in.a_num;
                r_ad  <= i_in.a_den;
                r_bn  <= i_in.b_num;
                r_bd  <= i_in.b_den;
            end
            ST_MUL_L: r_pl <= prod;
            ST_MUL_R: r_pr <= prod;
            ST_MUL_D: r_pd <= prod;
            ST_FORM: begin
                r_num   <= '0;
                r_den   <= '0;
                r_cmp   <= 1'b0;
                r_undef <= 1'b0;
                if (arith) begin
                    r_num <= n_num;
                    r_den <= r_pd;
                    if (n_num == 0) begin
                        r_den <= PW'(mag(NW'(r_pd)));
                    end else if (r_pd == 0) begin
                        r_undef <= 1'b1;
                    end
                end else if (is_cmp) begin
                    r_cmp <= n_cmp;
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    r_num <= r_num[NW-1] ? -$signed(quot) : $signed(quot);
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    r_den <= r_den[PW-1] ? -$signed(quot[PW-1:0]) : $signed(quot[PW-1:0]);
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready         = r_state == ST_IDLE;
    assign o_out.valid        = r_state == ST_OUT;
    assign o_out.res_num      = RNW'(r_num);
    assign o_out.res_den      = RDW'(r_den);
    assign o_out.compare_true = r_cmp;
    assign o_out.undefined    = r_undef;

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input ready while an item is in progress");
    a_undef_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.undefined |-> o_out.res_den == 0 && !o_out.compare_true)
        else $error("undefined result with nonzero denominator or compare flag");
    a_gcd_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gcd_done |-> r_state == ST_GCD)
        else $error("gcd completion outside gcd phase");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.compare_true |-> o_out.res_num == 0 && o_out.res_den == 0)
        else $error("comparison result carries a fraction");
endmodule
`default_nettype wire

// ===== rtl/rau_gcd.sv =====
// Binary gcd of two nonzero magnitudes, one shift or subtract per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_gcd import rau_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_unit_req i_req,
    output logic           o_done,
    output logic [MW-1:0]  o_gcd
);
    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic [MW-1:0] r_g;
    logic [KW-1:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_x    <= i_req.a;
                r_y    <= i_req.b;
                r_k    <= '0;
            end else if (r_busy) begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x == r_y) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_g    <= r_x << r_k;
                end else if (r_x > r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;
endmodule
`default_nettype wire

// ===== rtl/rau_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_div import rau_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_unit_req i_req,
    output logic           o_done,
    output logic [MW-1:0]  o_quot
);
    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_q;
    logic [MW-1:0] r_d;
    logic [KW-1:0] r_cnt;
    logic [MW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_q[MW-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_q    <= i_req.a;
                r_d    <= i_req.b;
                r_cnt  <= KW'(MW - 1);
            end else if (r_busy) begin
                r_rem <= fits ? MW'(trial - {1'b0, r_d}) : trial[MW-1:0];
                r_q   <= {r_q[MW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire
